/* hw/rtl/cmlcg_pkg.sv */
// Shared constants and command codes of the combined multiplicative random generator.
`timescale 1ns / 1ps

package cmlcg_pkg;

    localparam int unsigned STATE_W = 31;
    localparam int unsigned MUL_W   = 16;
    localparam int unsigned PROD_W  = STATE_W + MUL_W;

    // First generator: modulus 2^31 - 1, so the high part of a product folds back with weight 1.
    localparam logic [STATE_W-1:0] MOD_FIRST  = 31'd2147483647;
    localparam logic [MUL_W-1:0]   MUL_FIRST  = 16'd48271;

    // Second generator: modulus 2^31 - 249, so the high part folds back with weight 249.
    localparam logic [STATE_W-1:0] MOD_SECOND = 31'd2147483399;
    localparam logic [MUL_W-1:0]   MUL_SECOND = 16'd40692;

    typedef logic [STATE_W-1:0] t_state;

    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_FIRST  = 2'd1,
        CMD_RESEED = 2'd2
    } t_cmd;

endpackage

/* hw/rtl/cmlcg_if.sv */
// Valid/ready channel interfaces for the command items and the random value items.
`timescale 1ns / 1ps

interface cmlcg_cmd_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            command;
    cmlcg_pkg::t_state     seed_first;
    cmlcg_pkg::t_state     seed_second;

    modport source (output valid, output command, output seed_first, output seed_second,
                    input ready);
    modport sink   (input valid, input command, input seed_first, input seed_second,
                    output ready);
endinterface

interface cmlcg_rnd_if;
    logic                  valid;
    logic                  ready;
    cmlcg_pkg::t_state     random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

/* hw/rtl/combined_mlcg_random_generator.sv */
// Top level of the combined multiplicative congruential random generator.
`timescale 1ns / 1ps

// Channel    | Direction | Handshake       | Payload
// -----------+-----------+-----------------+-------------------------------------------
// i_cmd_ch   | in        | valid / ready   | command, seed_first, seed_second
// o_rnd_ch   | out       | valid / ready   | random_value (draw commands only)
//
// One item is accepted every cycle while the stages ahead can move or have room; a stalled
// output holds it back. A draw passes stage 1, stage 2 and the output register before it shows.
// The rate is set by the state loop in the second stage: one constant multiply, a modular
// fold and one conditional subtract per generator close on the state registers each cycle.
// The combining compare and subtract sits in the stage after it, in front of the output register.
// Reset (i_rst_n low at a clock edge) empties all stages and sets both generator states to 1.
// A stalled result is held in the output register while the two stages before it still fill.

module combined_mlcg_random_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cmlcg_cmd_if.sink          i_cmd_ch,
    cmlcg_rnd_if.source        o_rnd_ch
);

    // Next first state: x * 48271 mod (2^31 - 1). Since 2^31 is congruent to 1, the
    // product's high bits simply add to its low 31 bits, and one subtract finishes it.
    function automatic cmlcg_pkg::t_state next_first(input cmlcg_pkg::t_state s);
        logic [cmlcg_pkg::PROD_W-1:0] prod;
        logic [cmlcg_pkg::STATE_W:0]  sum;
        prod = cmlcg_pkg::PROD_W'(s) * cmlcg_pkg::PROD_W'(cmlcg_pkg::MUL_FIRST);
        sum  = (cmlcg_pkg::STATE_W+1)'(prod[cmlcg_pkg::STATE_W-1:0])
             + (cmlcg_pkg::STATE_W+1)'(prod[cmlcg_pkg::PROD_W-1:cmlcg_pkg::STATE_W]);
        if (sum >= (cmlcg_pkg::STATE_W+1)'(cmlcg_pkg::MOD_FIRST)) begin
            sum = sum - (cmlcg_pkg::STATE_W+1)'(cmlcg_pkg::MOD_FIRST);
        end
        return sum[cmlcg_pkg::STATE_W-1:0];
    endfunction

    // Next second state: y * 40692 mod (2^31 - 249). The high bits come back scaled by
    // 249, built from shifts as 256*h - 8*h + h. The sum stays below twice the modulus.
    function automatic cmlcg_pkg::t_state next_second(input cmlcg_pkg::t_state s);
        logic [cmlcg_pkg::PROD_W-1:0] prod;
        logic [cmlcg_pkg::MUL_W-1:0]  hi;
        logic [cmlcg_pkg::STATE_W:0]  fold;
        logic [cmlcg_pkg::STATE_W:0]  sum;
        prod = cmlcg_pkg::PROD_W'(s) * cmlcg_pkg::PROD_W'(cmlcg_pkg::MUL_SECOND);
        hi   = prod[cmlcg_pkg::PROD_W-1:cmlcg_pkg::STATE_W];
        fold = ((cmlcg_pkg::STATE_W+1)'(hi) << 8) - ((cmlcg_pkg::STATE_W+1)'(hi) << 3)
             + (cmlcg_pkg::STATE_W+1)'(hi);
        sum  = (cmlcg_pkg::STATE_W+1)'(prod[cmlcg_pkg::STATE_W-1:0]) + fold;
        if (sum >= (cmlcg_pkg::STATE_W+1)'(cmlcg_pkg::MOD_SECOND)) begin
            sum = sum - (cmlcg_pkg::STATE_W+1)'(cmlcg_pkg::MOD_SECOND);
        end
        return sum[cmlcg_pkg::STATE_W-1:0];
    endfunction

    // Stage 1: registered command item.
    logic                 r_s1_valid;
    cmlcg_pkg::t_cmd      r_s1_cmd;
    cmlcg_pkg::t_state    r_s1_seed_first;
    cmlcg_pkg::t_state    r_s1_seed_second;

    // Generator states.
    cmlcg_pkg::t_state    r_x;
    cmlcg_pkg::t_state    r_y;
    cmlcg_pkg::t_state    n_x;
    cmlcg_pkg::t_state    n_y;

    // Stage 2: fresh states of a draw and whether it is a combined draw.
    logic                 r_s2_valid;
    logic                 r_s2_comb;
    cmlcg_pkg::t_state    r_s2_x;
    cmlcg_pkg::t_state    r_s2_y;
    logic                 n_draw;
    logic                 n_comb;

    // Output register.
    logic                 r_out_valid;
    cmlcg_pkg::t_state    r_out_value;
    cmlcg_pkg::t_state    n_out_value;

    logic                 out_free;
    logic                 s2_free;
    logic                 s1_free;
    logic                 s1_adv;
    logic                 in_fire;

    // Each stage can take a new item when it is empty or its item moves on this cycle.
    assign out_free = !r_out_valid || o_rnd_ch.ready;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_adv   = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign in_fire  = i_cmd_ch.valid && s1_free;

    assign i_cmd_ch.ready        = s1_free;
    assign o_rnd_ch.valid        = r_out_valid;
    assign o_rnd_ch.random_value = r_out_value;

    // State update for the command in stage 1.
    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_draw = 1'b0;
        n_comb = 1'b0;
        unique case (r_s1_cmd)
            cmlcg_pkg::CMD_DRAW: begin
                n_x    = next_first(r_x);
                n_y    = next_second(r_y);
                n_draw = 1'b1;
                n_comb = 1'b1;
            end
            cmlcg_pkg::CMD_FIRST: begin
                n_x    = next_first(r_x);
                n_draw = 1'b1;
            end
            cmlcg_pkg::CMD_RESEED: begin
                n_x = r_s1_seed_first;
                n_y = r_s1_seed_second;
            end
            default: begin
                // The unused command code leaves the states alone and gives no result.
                n_draw = 1'b0;
            end
        endcase
    end

    // Combined draw: x - y when x > y, else x + (M2 - 1) - y, which is (M2 - 1) - (y - x); a first-only draw gives x.
    always_comb begin
        if (!r_s2_comb) begin
            n_out_value = r_s2_x;
        end else if (r_s2_x > r_s2_y) begin
            n_out_value = r_s2_x - r_s2_y;
        end else begin
            n_out_value = (cmlcg_pkg::MOD_SECOND - cmlcg_pkg::STATE_W'(1)) - (r_s2_y - r_s2_x);
        end
    end

    // Control state and generator states.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_x         <= cmlcg_pkg::STATE_W'(1);
            r_y         <= cmlcg_pkg::STATE_W'(1);
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_cmd_ch.valid;
            end
            if (s1_adv) begin
                r_x <= n_x;
                r_y <= n_y;
            end
            if (s2_free) begin
                r_s2_valid <= s1_adv && n_draw;
            end
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cmd         <= cmlcg_pkg::t_cmd'(i_cmd_ch.command);
            r_s1_seed_first  <= i_cmd_ch.seed_first;
            r_s1_seed_second <= i_cmd_ch.seed_second;
        end
        if (s1_adv) begin
            r_s2_x    <= n_x;
            r_s2_y    <= n_y;
            r_s2_comb <= n_comb;
        end
        if (out_free && r_s2_valid) begin
            r_out_value <= n_out_value;
        end
    end

endmodule

/* hw/rtl/cmlcg_checker.sv */
// Port-level checks of the combined random generator and their bind to the top level.
`timescale 1ns / 1ps

module cmlcg_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  cmlcg_pkg::t_state  i_out_value
);

    // A result waiting at the output holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled random value changed or vanished");

    // Every value lies below the first modulus, so the all-ones word never appears.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_value != cmlcg_pkg::MOD_FIRST)
        else $error("random value out of range");

    // With no result pending, the pipeline behind the output is free and takes an item.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while the output is empty");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result present right after reset");

endmodule

bind combined_mlcg_random_generator cmlcg_checker u_cmlcg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd_ch.ready),
    .i_out_valid (o_rnd_ch.valid),
    .i_out_ready (o_rnd_ch.ready),
    .i_out_value (o_rnd_ch.random_value)
);
